FILE: src/lbmsc_pkg.sv
`timescale 1ns / 1ps

package lbmsc_pkg;

  // Fixed-point format and grid
  localparam int FRAC_BITS   = 24;
  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int NUM_DIR     = 9;

  // Shared unit widths
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int EXT_W  = 72;
  localparam int DIV_W  = 60;
  localparam int DSR_W  = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAU      = 1'b1;

  // Constants in the extended width
  localparam logic signed [EXT_W-1:0] ONE_X   = 72'sd1 <<< FRAC_BITS;
  localparam logic signed [EXT_W-1:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [EXT_W-1:0] S32_MIN = -72'sd2147483648;
  localparam logic signed [EXT_W-1:0] HALF30  = 72'sd1 <<< 29;

  // Register reset values and tau floor
  localparam logic signed [31:0] COUPLING_RST = -(32'sd5 <<< FRAC_BITS);
  localparam logic [30:0] TAU_RST = 31'(64'd1 << FRAC_BITS);
  localparam logic [30:0] TAU_MIN = 31'(64'd1 << (FRAC_BITS - 1));

  // Lattice weights
  localparam int W_CENTER = (8 * (1 << FRAC_BITS) + 9) / 18;
  localparam int W_AXIS   = (2 * (1 << FRAC_BITS) + 9) / 18;
  localparam int W_DIAG   = (2 * (1 << FRAC_BITS) + 36) / 72;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [DSR_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DIV_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFFFFFF;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round half up, then drop FRAC_BITS fraction bits
  function automatic logic signed [EXT_W-1:0] rsr_fb(input logic signed [EXT_W-1:0] v);
    return (v + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [EXT_W-1:0] rsr1(input logic signed [EXT_W-1:0] v);
    return (v + 72'sd1) >>> 1;
  endfunction

  // Multiply by a lattice component of -1, 0 or +1
  function automatic logic signed [EXT_W-1:0] cterm(input logic signed [1:0] c,
                                                    input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] r;
    if (c == 2'sd1) r = v;
    else if (c == -2'sd1) r = -v;
    else r = '0;
    return r;
  endfunction

  function automatic logic signed [1:0] dir_cx(input logic [3:0] d);
    logic signed [1:0] r;
    case (d)
      4'd1, 4'd5, 4'd8: r = 2'sd1;
      4'd3, 4'd6, 4'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_cy(input logic [3:0] d);
    logic signed [1:0] r;
    case (d)
      4'd2, 4'd5, 4'd6: r = 2'sd1;
      4'd4, 4'd7, 4'd8: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] dir_weight(input logic [3:0] d);
    logic [31:0] r;
    case (d)
      4'd0:                   r = 32'(W_CENTER);
      4'd1, 4'd2, 4'd3, 4'd4: r = 32'(W_AXIS);
      default:                r = 32'(W_DIAG);
    endcase
    return r;
  endfunction

  // exp(-n) in Q30
  function automatic logic [30:0] exp_int_q30(input logic [3:0] n);
    logic [30:0] r;
    case (n)
      4'd0:    r = 31'd1073741824;
      4'd1:    r = 31'd395007542;
      4'd2:    r = 31'd145315154;
      4'd3:    r = 31'd53458458;
      4'd4:    r = 31'd19666267;
      4'd5:    r = 31'd7234816;
      4'd6:    r = 31'd2661540;
      4'd7:    r = 31'd979126;
      4'd8:    r = 31'd360200;
      4'd9:    r = 31'd132510;
      4'd10:   r = 31'd48748;
      4'd11:   r = 31'd17933;
      4'd12:   r = 31'd6597;
      4'd13:   r = 31'd2427;
      4'd14:   r = 31'd893;
      default: r = 31'd328;
    endcase
    return r;
  endfunction

endpackage

FILE: src/lbmsc_mul.sv
`timescale 1ns / 1ps

module lbmsc_mul (
  input  logic                                 clk,
  input  logic signed [lbmsc_pkg::MUL_W-1:0]   a,
  input  logic signed [lbmsc_pkg::MUL_W-1:0]   b,
  output logic signed [lbmsc_pkg::PROD_W-1:0]  p
);

  logic signed [lbmsc_pkg::PROD_W-1:0] p_r;

  // Register every product
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

FILE: src/lbmsc_div.sv
`timescale 1ns / 1ps

module lbmsc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lbmsc_pkg::div_req_t   req,
  output lbmsc_pkg::div_rsp_t   rsp
);

  localparam int W  = lbmsc_pkg::DIV_W;
  localparam int DW = lbmsc_pkg::DSR_W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  logic [DW-1:0] rem_r;
  logic [W-1:0]  quo_r;
  logic [DW-1:0] dsr_r;

  logic [W-1:0]  mag;
  logic [DW:0]   rem_sh;
  logic          ge;

  // Magnitude of the dividend; the divisor is always positive
  assign mag    = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= req.dividend[W-1];
        rem_r  <= '0;
        quo_r  <= mag;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DW-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: src/lbm_d2q9_shan_chen_cell_update.sv
`timescale 1ns / 1ps
// Each beat with a valid direction holds the input while psi runs through the shared
//   multiplier, unless psi clamps; a direction above eight skips psi.
// The ninth item adds 13 divides on the shared divider plus the multiplies of the
//   equilibrium, one direction at a time; a density error skips four of the divides.
// Input is taken only in idle, so a cell ends before the next begins; each output beat waits on out_tready.
// Reset: synchronous active-low rst_n clears sums, counters and handshakes.

module lbm_d2q9_shan_chen_cell_update (
  input  logic          clk,
  input  logic          rst_n,
  // cell_x[7:0], cell_y[15:8], direction[19:16], population[51:20],
  // neighbour_density[83:52], zero pad
  input  logic [87:0]   in_tdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  // dest_x[7:0], dest_y[15:8], out_direction[19:16], relaxed_population[51:20],
  // cell_density[83:52], velocity_x[115:84], velocity_y[147:116], zero pad
  output logic [151:0]  out_tdata,
  // density_error[0]
  output logic          out_tuser,
  output logic          out_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_we,
  input  logic [lbmsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int FB = lbmsc_pkg::FRAC_BITS;
  localparam int XW = lbmsc_pkg::EXT_W;

  // Sequencer states
  localparam logic [5:0] ST_IDLE = 6'd0;
  localparam logic [5:0] ST_P0   = 6'd1;
  localparam logic [5:0] ST_P1   = 6'd2;
  localparam logic [5:0] ST_P2   = 6'd3;
  localparam logic [5:0] ST_P3   = 6'd4;
  localparam logic [5:0] ST_P4   = 6'd5;
  localparam logic [5:0] ST_P5   = 6'd6;
  localparam logic [5:0] ST_P6   = 6'd7;
  localparam logic [5:0] ST_P7   = 6'd8;
  localparam logic [5:0] ST_P8   = 6'd9;
  localparam logic [5:0] ST_P9   = 6'd10;
  localparam logic [5:0] ST_F0   = 6'd11;
  localparam logic [5:0] ST_F1   = 6'd12;
  localparam logic [5:0] ST_IEND = 6'd13;
  localparam logic [5:0] ST_C0   = 6'd14;
  localparam logic [5:0] ST_C1   = 6'd15;
  localparam logic [5:0] ST_C2   = 6'd16;
  localparam logic [5:0] ST_C3   = 6'd17;
  localparam logic [5:0] ST_C4   = 6'd18;
  localparam logic [5:0] ST_C5   = 6'd19;
  localparam logic [5:0] ST_C6   = 6'd20;
  localparam logic [5:0] ST_C7   = 6'd21;
  localparam logic [5:0] ST_C8   = 6'd22;
  localparam logic [5:0] ST_U0   = 6'd23;
  localparam logic [5:0] ST_U1   = 6'd24;
  localparam logic [5:0] ST_U2   = 6'd25;
  localparam logic [5:0] ST_U3   = 6'd26;
  localparam logic [5:0] ST_K0   = 6'd27;
  localparam logic [5:0] ST_K1   = 6'd28;
  localparam logic [5:0] ST_K2   = 6'd29;
  localparam logic [5:0] ST_K3   = 6'd30;
  localparam logic [5:0] ST_K4   = 6'd31;
  localparam logic [5:0] ST_K5   = 6'd32;
  localparam logic [5:0] ST_K6   = 6'd33;
  localparam logic [5:0] ST_K7   = 6'd34;
  localparam logic [5:0] ST_K8   = 6'd35;
  localparam logic [5:0] ST_K9   = 6'd36;
  localparam logic [5:0] ST_K10  = 6'd37;

  logic [5:0] state_r, state_nxt;

  // Input fields
  logic [7:0]         in_x, in_y;
  logic [3:0]         in_dir;
  logic signed [31:0] in_pop, in_nb;
  logic               in_acc;

  assign in_x   = in_tdata[7:0];
  assign in_y   = in_tdata[15:8];
  assign in_dir = in_tdata[19:16];
  assign in_pop = in_tdata[51:20];
  assign in_nb  = in_tdata[83:52];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration and accumulators
  logic signed [31:0] coupling_r;
  logic [30:0]        tau_r;
  logic [30:0]        tau_eff;
  logic signed [31:0] dens_r, momx_r, momy_r, fsx_r, fsy_r;
  logic signed [31:0] pops_r [lbmsc_pkg::NUM_DIR];
  logic [3:0]         items_r;
  logic [15:0]        coord_r;
  logic [3:0]         dir_r;

  // Psi unit scratch
  logic signed [31:0] psi_x_r;
  logic               psi_cell_r;
  logic [3:0]         n_r;
  logic [21:0]        y_r;
  logic [13:0]        y2_r;
  logic [30:0]        ppart_r;
  logic [30:0]        p_r;
  logic [2:0]         sq_cnt_r;
  logic [FB:0]        psi_r;
  logic [29:0]        psi_frac;

  // Cell scratch
  logic               axis_r;
  logic signed [32:0] t_r;
  logic signed [31:0] fx_r;
  logic signed [34:0] nvx_r, nvy_r;
  logic signed [31:0] vx_r, vy_r;
  logic               err_r;
  logic signed [40:0] usq_r;
  logic [3:0]         k_r;
  logic signed [31:0] cu_r;
  logic signed [39:0] cu2_r;
  logic signed [31:0] poly_r;
  logic signed [32:0] wr_r;
  logic signed [31:0] feq_r;
  logic signed [31:0] res_r;

  // Output register
  logic               out_valid_r;
  logic [7:0]         out_dx_r, out_dy_r;
  logic [3:0]         out_dir_r;
  logic signed [31:0] out_res_r, out_rho_r, out_vx_r, out_vy_r;
  logic               out_err_r, out_last_r;
  logic               out_load;

  // Shared units
  logic signed [lbmsc_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [lbmsc_pkg::PROD_W-1:0] mul_p;
  lbmsc_pkg::div_req_t div_req;
  lbmsc_pkg::div_rsp_t div_rsp;

  lbmsc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  lbmsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign tau_eff  = (tau_r < lbmsc_pkg::TAU_MIN) ? lbmsc_pkg::TAU_MIN : tau_r;
  assign psi_frac = 30'(psi_x_r[FB-1:0]) << (30 - FB);
  assign out_load = (state_r == ST_K10) && (!out_valid_r || out_tready);

  // Destination coordinates with periodic wrap
  logic [8:0]  x0, y0;
  logic [9:0]  dx_sum, dy_sum;
  assign x0 = 9'(coord_r[7:0]) % 9'(lbmsc_pkg::GRID_WIDTH);
  assign y0 = 9'(coord_r[15:8]) % 9'(lbmsc_pkg::GRID_HEIGHT);
  assign dx_sum = 10'(x0) + 10'(lbmsc_pkg::GRID_WIDTH)
                + 10'(lbmsc_pkg::dir_cx(k_r) == 2'sd1) - 10'(lbmsc_pkg::dir_cx(k_r) == -2'sd1);
  assign dy_sum = 10'(y0) + 10'(lbmsc_pkg::GRID_HEIGHT)
                + 10'(lbmsc_pkg::dir_cy(k_r) == 2'sd1) - 10'(lbmsc_pkg::dir_cy(k_r) == -2'sd1);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_P1: begin mul_a = 34'(y_r);  mul_b = 34'(y_r); end
      ST_P3: begin mul_a = 34'(y2_r); mul_b = 34'(y_r); end
      ST_P6: begin mul_a = 34'(p_r);  mul_b = 34'(p_r); end
      ST_P8: begin mul_a = 34'(lbmsc_pkg::exp_int_q30(n_r)); mul_b = 34'(p_r); end
      ST_F0: begin mul_a = 34'(lbmsc_pkg::dir_weight(dir_r)); mul_b = 34'(psi_r); end
      ST_C1: begin
        mul_a = 34'(psi_r);
        mul_b = axis_r ? 34'(fsy_r) : 34'(fsx_r);
      end
      ST_C3: begin mul_a = 34'(coupling_r); mul_b = 34'(t_r); end
      ST_U0: begin mul_a = 34'(vx_r); mul_b = 34'(vx_r); end
      ST_U2: begin mul_a = 34'(vy_r); mul_b = 34'(vy_r); end
      ST_K1: begin mul_a = 34'(cu_r); mul_b = 34'(cu_r); end
      ST_K4: begin mul_a = 34'(lbmsc_pkg::dir_weight(k_r)); mul_b = 34'(dens_r); end
      ST_K6: begin mul_a = 34'(wr_r); mul_b = 34'(poly_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider request
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 32'(tau_eff);
    case (state_r)
      ST_C5: begin
        div_req.start    = 1'b1;
        div_req.dividend = 60'(XW'(fx_r) <<< FB);
      end
      ST_C7: begin
        div_req.start    = 1'b1;
        div_req.dividend = axis_r ? 60'(XW'(nvy_r) <<< FB) : 60'(XW'(nvx_r) <<< FB);
        div_req.divisor  = 32'(dens_r);
      end
      ST_K8: begin
        div_req.start    = 1'b1;
        div_req.dividend = 60'((XW'(pops_r[k_r]) - XW'(feq_r)) <<< FB);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = (in_dir < 4'(lbmsc_pkg::NUM_DIR)) ? ST_P0 : ST_IEND;
      end
      ST_P0: begin
        if (psi_x_r <= 32'sd0 || psi_x_r >= (32'sd16 <<< FB)) begin
          state_nxt = psi_cell_r ? ST_C1 : ST_F0;
        end else begin
          state_nxt = ST_P1;
        end
      end
      ST_P1: state_nxt = ST_P2;
      ST_P2: state_nxt = ST_P3;
      ST_P3: state_nxt = ST_P4;
      ST_P4: state_nxt = ST_P5;
      ST_P5: state_nxt = ST_P6;
      ST_P6: state_nxt = ST_P7;
      ST_P7: state_nxt = (sq_cnt_r == 3'd7) ? ST_P8 : ST_P6;
      ST_P8: state_nxt = ST_P9;
      ST_P9: state_nxt = psi_cell_r ? ST_C1 : ST_F0;
      ST_F0: state_nxt = ST_F1;
      ST_F1: state_nxt = ST_IEND;
      ST_IEND: state_nxt = (items_r == 4'(lbmsc_pkg::NUM_DIR - 1)) ? ST_C0 : ST_IDLE;
      ST_C0: state_nxt = (dens_r <= 32'sd0) ? ST_U0 : ST_P0;
      ST_C1: state_nxt = ST_C2;
      ST_C2: state_nxt = ST_C3;
      ST_C3: state_nxt = ST_C4;
      ST_C4: state_nxt = ST_C5;
      ST_C5: state_nxt = ST_C6;
      ST_C6: if (div_rsp.done) state_nxt = axis_r ? ST_C7 : ST_C1;
      ST_C7: state_nxt = ST_C8;
      ST_C8: if (div_rsp.done) state_nxt = axis_r ? ST_U0 : ST_C7;
      ST_U0: state_nxt = ST_U1;
      ST_U1: state_nxt = ST_U2;
      ST_U2: state_nxt = ST_U3;
      ST_U3: state_nxt = ST_K0;
      ST_K0: state_nxt = ST_K1;
      ST_K1: state_nxt = ST_K2;
      ST_K2: state_nxt = ST_K3;
      ST_K3: state_nxt = ST_K4;
      ST_K4: state_nxt = ST_K5;
      ST_K5: state_nxt = ST_K6;
      ST_K6: state_nxt = ST_K7;
      ST_K7: state_nxt = ST_K8;
      ST_K8: state_nxt = ST_K9;
      ST_K9: if (div_rsp.done) state_nxt = ST_K10;
      ST_K10: if (out_load) begin
        state_nxt = (k_r == 4'(lbmsc_pkg::NUM_DIR - 1)) ? ST_IDLE : ST_K0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coupling_r  <= lbmsc_pkg::COUPLING_RST;
      tau_r       <= lbmsc_pkg::TAU_RST;
      dens_r      <= '0;
      momx_r      <= '0;
      momy_r      <= '0;
      fsx_r       <= '0;
      fsy_r       <= '0;
      items_r     <= '0;
      coord_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          lbmsc_pkg::REG_COUPLING: coupling_r <= cfg_wdata;
          lbmsc_pkg::REG_TAU:      tau_r      <= cfg_wdata[30:0];
          default:                 tau_r      <= tau_r;
        endcase
      end

      // Accumulate on each accepted beat
      if (in_acc) begin
        if (items_r == 4'd0) coord_r <= {in_y, in_x};
        if (in_dir < 4'(lbmsc_pkg::NUM_DIR)) begin
          dens_r <= lbmsc_pkg::sat32(XW'(dens_r) + XW'(in_pop));
          momx_r <= lbmsc_pkg::sat32(XW'(momx_r)
                    + lbmsc_pkg::cterm(lbmsc_pkg::dir_cx(in_dir), XW'(in_pop)));
          momy_r <= lbmsc_pkg::sat32(XW'(momy_r)
                    + lbmsc_pkg::cterm(lbmsc_pkg::dir_cy(in_dir), XW'(in_pop)));
        end
      end

      // Add the weighted psi into the force sums
      if (state_r == ST_F1) begin
        fsx_r <= lbmsc_pkg::sat32(XW'(fsx_r) + lbmsc_pkg::cterm(lbmsc_pkg::dir_cx(dir_r),
                 lbmsc_pkg::rsr_fb(XW'(mul_p))));
        fsy_r <= lbmsc_pkg::sat32(XW'(fsy_r) + lbmsc_pkg::cterm(lbmsc_pkg::dir_cy(dir_r),
                 lbmsc_pkg::rsr_fb(XW'(mul_p))));
      end

      if (state_r == ST_IEND) items_r <= items_r + 4'd1;

      // Clear the cell when its last beat is loaded into the output register
      if (out_load && k_r == 4'(lbmsc_pkg::NUM_DIR - 1)) begin
        dens_r  <= '0;
        momx_r  <= '0;
        momy_r  <= '0;
        fsx_r   <= '0;
        fsy_r   <= '0;
        items_r <= '0;
      end

      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dir_r      <= in_dir;
      psi_x_r    <= in_nb;
      psi_cell_r <= 1'b0;
      if (in_dir < 4'(lbmsc_pkg::NUM_DIR)) pops_r[in_dir] <= in_pop;
    end

    case (state_r)
      // Psi: clamp ends, split integer and fraction
      ST_P0: begin
        if (psi_x_r <= 32'sd0) psi_r <= '0;
        else if (psi_x_r >= (32'sd16 <<< FB)) psi_r <= (FB+1)'(lbmsc_pkg::ONE_X);
        n_r <= psi_x_r[FB+3:FB];
        y_r <= psi_frac[29:8];
      end
      ST_P2: y2_r <= mul_p[43:30];
      // Divide the cubic term by six through a reciprocal multiply
      ST_P4: ppart_r <= 31'(32'd1 << 30) - 31'(y_r) + 31'(y2_r >> 1)
                        - 31'((12'(mul_p[35:30]) * 12'd43) >> 8);
      ST_P5: begin
        p_r      <= ppart_r;
        sq_cnt_r <= '0;
      end
      ST_P7: begin
        p_r      <= 31'((XW'(mul_p) + lbmsc_pkg::HALF30) >>> 30);
        sq_cnt_r <= sq_cnt_r + 3'd1;
      end
      ST_P9: begin
        psi_r <= (FB+1)'(lbmsc_pkg::ONE_X
                 - ((((XW'(mul_p) + lbmsc_pkg::HALF30) >>> 30)
                     + (72'sd1 <<< (29 - FB))) >>> (30 - FB)));
      end
      // Cell: psi of own density or the zero-velocity path
      ST_C0: begin
        axis_r     <= 1'b0;
        err_r      <= (dens_r <= 32'sd0);
        psi_x_r    <= dens_r;
        psi_cell_r <= 1'b1;
        if (dens_r <= 32'sd0) begin
          vx_r <= '0;
          vy_r <= '0;
        end
      end
      ST_C2: t_r <= 33'(lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_C4: fx_r <= lbmsc_pkg::sat32(-lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_C6: if (div_rsp.done) begin
        if (axis_r) nvy_r <= 35'(XW'(momy_r) + XW'(div_rsp.quot));
        else        nvx_r <= 35'(XW'(momx_r) + XW'(div_rsp.quot));
        axis_r <= !axis_r;
      end
      ST_C8: if (div_rsp.done) begin
        if (axis_r) vy_r <= lbmsc_pkg::sat32(XW'(div_rsp.quot));
        else        vx_r <= lbmsc_pkg::sat32(XW'(div_rsp.quot));
        axis_r <= !axis_r;
      end
      // Squared speed
      ST_U1: usq_r <= 41'(lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_U3: begin
        usq_r <= 41'(XW'(usq_r) + lbmsc_pkg::rsr_fb(XW'(mul_p)));
        k_r   <= '0;
      end
      // Equilibrium and relaxation per direction
      ST_K0: cu_r <= lbmsc_pkg::sat32(lbmsc_pkg::cterm(lbmsc_pkg::dir_cx(k_r), XW'(vx_r))
                     + lbmsc_pkg::cterm(lbmsc_pkg::dir_cy(k_r), XW'(vy_r)));
      ST_K2: cu2_r <= 40'(lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_K3: poly_r <= lbmsc_pkg::sat32(lbmsc_pkg::ONE_X + 72'sd3 * XW'(cu_r)
                       + lbmsc_pkg::rsr1(72'sd9 * XW'(cu2_r))
                       - lbmsc_pkg::rsr1(72'sd3 * XW'(usq_r)));
      ST_K5: wr_r <= 33'(lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_K7: feq_r <= lbmsc_pkg::sat32(lbmsc_pkg::rsr_fb(XW'(mul_p)));
      ST_K9: if (div_rsp.done) begin
        res_r <= lbmsc_pkg::sat32(XW'(pops_r[k_r]) - XW'(div_rsp.quot));
      end
      ST_K10: if (out_load) begin
        out_dx_r   <= 8'(dx_sum % 10'(lbmsc_pkg::GRID_WIDTH));
        out_dy_r   <= 8'(dy_sum % 10'(lbmsc_pkg::GRID_HEIGHT));
        out_dir_r  <= k_r;
        out_res_r  <= res_r;
        out_rho_r  <= dens_r;
        out_vx_r   <= vx_r;
        out_vy_r   <= vy_r;
        out_err_r  <= err_r;
        out_last_r <= (k_r == 4'(lbmsc_pkg::NUM_DIR - 1));
        k_r        <= k_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_vy_r, out_vx_r, out_rho_r, out_res_r,
                       out_dir_r, out_dy_r, out_dx_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_last_on_dir8: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_dir_r == 4'd8)
    else $error("last beat not on direction eight");

  a_err_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_vx_r == 32'sd0 && out_vy_r == 32'sd0)
    else $error("density error with nonzero velocity");

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_rsp.busy)
    else $error("divider busy while accepting input");

  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> items_r <= 4'd8)
    else $error("item count beyond one cell in idle");
`endif

endmodule
